// ===== sv/atpr_pkg.sv =====
// Shared constants, types and the arctangent table for the accelerometer
// tilt / roll / magnitude core. No dependencies.
package atpr_pkg;

    // default sample width and CORDIC depth
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // result word widths
    localparam int TILT_W = 15;
    localparam int ROLL_W = 16;
    localparam int MAG_W  = 16;

    // vectors enter the CORDIC scaled by 2^VEC_SHIFT
    localparam int VEC_SHIFT = 16;

    // angle accumulator: 0.01 degree with ANG_FRAC fraction bits
    localparam int ANG_W    = 28;
    localparam int ANG_FRAC = 12;
    localparam int RND_W    = ANG_W - ANG_FRAC;

    localparam int ATAN_LEN = 24;

    localparam logic signed [ANG_W-1:0] RIGHT_Q12 = 28'sd36864000;
    localparam logic signed [ANG_W-1:0] RND_POS   = 28'sd2048;
    localparam logic signed [ANG_W-1:0] RND_NEG   = 28'sd2047;

    localparam logic signed [RND_W-1:0] TILT_LIM = 16'sd9000;
    localparam logic signed [RND_W-1:0] ROLL_LIM = 16'sd18000;
    localparam logic signed [RND_W-1:0] RIGHT_DEG = 16'sd9000;

    localparam logic [MAG_W-1:0] MAG_MAX = 16'hFFFF;

    // atan(2^-i) in 1/4096 of 0.01 degree
    localparam logic signed [ANG_W-1:0] ATAN_Q12 [ATAN_LEN] = '{
        28'sd18432000, 28'sd10881045, 28'sd5749245, 28'sd2918407,
        28'sd1464867,  28'sd733147,   28'sd366663,  28'sd183343,
        28'sd91673,    28'sd45837,    28'sd22918,   28'sd11459,
        28'sd5730,     28'sd2865,     28'sd1432,    28'sd716,
        28'sd358,      28'sd179,      28'sd90,      28'sd45,
        28'sd22,       28'sd11,       28'sd6,       28'sd3
    };

    // how the roll angle is formed at the output
    typedef enum logic [2:0] {
        ROLL_VEC,
        ROLL_ZERO,
        ROLL_FLIP,
        ROLL_POS90,
        ROLL_NEG90
    } t_roll_sel;

endpackage

// ===== sv/atpr_if.sv =====
// Sample and result channel interfaces (valid/ready plus payload).
// Depends on atpr_pkg for default widths.
interface atpr_smp_if #(
    parameter int SAMPLE_BITS = atpr_pkg::SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

interface atpr_res_if ();
    import atpr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [TILT_W-1:0] tilt_x_angle;
    logic signed [ROLL_W-1:0] neg_roll_angle;
    logic [MAG_W-1:0]         magnitude;

    modport source (output valid, output tilt_x_angle, output neg_roll_angle,
                    output magnitude, input ready);
    modport sink   (input valid, input tilt_x_angle, input neg_roll_angle,
                    input magnitude, output ready);
endinterface

// ===== sv/accel_tilt_pitch_roll_core.sv =====
// Throughput: one word per cycle when the output is not stalled; every square-root and
// CORDIC cell is a single pipeline stage, so the rate is set by the stall chain only.
// Stalled stages hold; empty stages keep filling while the output word waits.
// Reset (synchronous, active low) clears the stage valid bits; payload is not reset.
module accel_tilt_pitch_roll_core #(
    parameter int SAMPLE_BITS   = atpr_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STAGES = atpr_pkg::CORDIC_STAGES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    atpr_smp_if.sink   i_smp,
    atpr_res_if.source o_res
);
    import atpr_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int CS = CORDIC_STAGES;
    localparam int NW = 2 * SB;
    localparam int CW = SB + VEC_SHIFT + 2;
    localparam int MW = (SB > MAG_W) ? SB : MAG_W;

    // stage positions
    localparam int ST_SQ    = 0;
    localparam int ST_SUM   = 1;
    localparam int ST_ROOT0 = 2;
    localparam int ST_INIT  = ST_ROOT0 + SB;
    localparam int ST_CORD0 = ST_INIT + 1;
    localparam int ST_RND   = ST_CORD0 + CS;
    localparam int ST_OUT   = ST_RND + 1;
    localparam int NS       = ST_OUT + 1;

    typedef struct packed {
        logic signed [SB-1:0] ax;
        logic signed [SB-1:0] ay;
        logic signed [SB-1:0] az;
        logic                 tz;
        t_roll_sel            sel;
    } t_side;

    typedef struct packed {
        logic             tz;
        t_roll_sel        sel;
        logic [MAG_W-1:0] mag;
    } t_tail;

    function automatic logic signed [RND_W-1:0] clamp_ang(
        input logic signed [RND_W-1:0] v,
        input logic signed [RND_W-1:0] lim
    );
        logic signed [RND_W-1:0] res;
        res = v;
        if (v > lim) res = lim;
        if (v < -lim) res = -lim;
        return res;
    endfunction

    // ---------------------------------------------------------------- flow
    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS:0]   w_adv;

    // advance a stage when it is empty or the next one advances
    assign w_adv[NS] = o_res.ready;
    for (genvar k = 0; k < NS; k++) begin : g_adv
        assign w_adv[k] = ~r_vld[k] | w_adv[k+1];
    end

    assign n_vld = {r_vld[NS-2:0], i_smp.valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_adv[k]) r_vld[k] <= n_vld[k];
            end
        end
    end

    assign i_smp.ready = w_adv[0];
    assign o_res.valid = r_vld[ST_OUT];

    // ---------------------------------------------------------------- squares
    logic signed [NW-1:0] w_px;
    logic signed [NW-1:0] w_py;
    logic signed [NW-1:0] w_pz;
    logic [NW-1:0]        r_sq_x;
    logic [NW-1:0]        r_sq_y;
    logic [NW-1:0]        r_sq_z;
    logic signed [SB-1:0] r_ax;
    logic signed [SB-1:0] r_ay;
    logic signed [SB-1:0] r_az;

    assign w_px = i_smp.accel_x * i_smp.accel_x;
    assign w_py = i_smp.accel_y * i_smp.accel_y;
    assign w_pz = i_smp.accel_z * i_smp.accel_z;

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_SQ]) begin
            r_sq_x <= w_px;
            r_sq_y <= w_py;
            r_sq_z <= w_pz;
            r_ax   <= i_smp.accel_x;
            r_ay   <= i_smp.accel_y;
            r_az   <= i_smp.accel_z;
        end
    end

    // ---------------------------------------------------------------- sums, roll case
    t_roll_sel     w_sel;
    logic          w_tz;
    logic [NW-1:0] r_syz;
    logic [NW-1:0] r_tot;
    t_side         r_side [SB+1];

    // pick out the axis-aligned roll cases
    always_comb begin
        w_tz = (r_ay == '0) && (r_az == '0);
        if (r_ay == '0) begin
            w_sel = r_az[SB-1] ? ROLL_FLIP : ROLL_ZERO;
        end else if (r_az == '0) begin
            w_sel = r_ay[SB-1] ? ROLL_NEG90 : ROLL_POS90;
        end else begin
            w_sel = ROLL_VEC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_SUM]) begin
            r_syz <= r_sq_y + r_sq_z;
            r_tot <= r_sq_x + r_sq_y + r_sq_z;
        end
    end

    // ---------------------------------------------------------------- square roots
    logic [NW-1:0] w_yz_num [SB+1];
    logic [NW-1:0] w_yz_res [SB+1];
    logic [NW-1:0] w_tt_num [SB+1];
    logic [NW-1:0] w_tt_res [SB+1];

    assign w_yz_num[0] = r_syz;
    assign w_yz_res[0] = '0;
    assign w_tt_num[0] = r_tot;
    assign w_tt_res[0] = '0;

    for (genvar k = 0; k < SB; k++) begin : g_root
        atpr_sqrt_cell #(.W(SB), .STEP(k)) u_yz (
            .i_clk (i_clk),
            .i_en  (w_adv[ST_ROOT0+k]),
            .i_num (w_yz_num[k]),
            .i_res (w_yz_res[k]),
            .o_num (w_yz_num[k+1]),
            .o_res (w_yz_res[k+1])
        );
        atpr_sqrt_cell #(.W(SB), .STEP(k)) u_tot (
            .i_clk (i_clk),
            .i_en  (w_adv[ST_ROOT0+k]),
            .i_num (w_tt_num[k]),
            .i_res (w_tt_res[k]),
            .o_num (w_tt_num[k+1]),
            .o_res (w_tt_res[k+1])
        );
    end

    // load the sample and carry it alongside the root cells
    always_ff @(posedge i_clk) begin
        if (w_adv[ST_SUM]) begin
            r_side[0] <= '{ax: r_ax, ay: r_ay, az: r_az, tz: w_tz, sel: w_sel};
        end
        for (int k = 0; k < SB; k++) begin
            if (w_adv[ST_ROOT0+k]) r_side[k+1] <= r_side[k];
        end
    end

    // ---------------------------------------------------------------- CORDIC setup
    t_side                w_s;
    logic [SB-1:0]        w_d;
    logic [MW-1:0]        w_mext;
    logic [MAG_W-1:0]     w_mag;
    logic signed [CW-1:0] w_dv;
    logic signed [CW-1:0] w_axv;
    logic signed [CW-1:0] w_ayv;
    logic signed [CW-1:0] w_azv;
    logic signed [CW-1:0] w_rx0;
    logic signed [CW-1:0] w_ry0;
    logic signed [ANG_W-1:0] w_ra0;
    logic signed [CW-1:0] r_tx0;
    logic signed [CW-1:0] r_ty0;
    logic signed [CW-1:0] r_rx0;
    logic signed [CW-1:0] r_ry0;
    logic signed [ANG_W-1:0] r_ra0;
    t_tail                r_tail [CS+1];

    assign w_s    = r_side[SB];
    assign w_d    = w_yz_res[SB][SB-1:0];
    assign w_mext = MW'(w_tt_res[SB][SB-1:0]);
    assign w_mag  = (w_mext > MW'(MAG_MAX)) ? MAG_MAX : w_mext[MAG_W-1:0];
    assign w_dv   = $signed(CW'({1'b0, w_d})) <<< VEC_SHIFT;
    assign w_axv  = CW'($signed(w_s.ax)) <<< VEC_SHIFT;
    assign w_ayv  = CW'($signed(w_s.ay)) <<< VEC_SHIFT;
    assign w_azv  = CW'($signed(w_s.az)) <<< VEC_SHIFT;

    // fold the roll vector into the right half plane
    always_comb begin
        if (!w_s.az[SB-1]) begin
            w_rx0 = w_azv;
            w_ry0 = w_ayv;
            w_ra0 = '0;
        end else if (!w_s.ay[SB-1]) begin
            w_rx0 = w_ayv;
            w_ry0 = -w_azv;
            w_ra0 = RIGHT_Q12;
        end else begin
            w_rx0 = -w_ayv;
            w_ry0 = w_azv;
            w_ra0 = -RIGHT_Q12;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_INIT]) begin
            r_tx0 <= w_dv;
            r_ty0 <= w_axv;
            r_rx0 <= w_rx0;
            r_ry0 <= w_ry0;
            r_ra0 <= w_ra0;
        end
    end

    // ---------------------------------------------------------------- CORDIC cells
    logic signed [CW-1:0]    w_tx [CS+1];
    logic signed [CW-1:0]    w_ty [CS+1];
    logic signed [ANG_W-1:0] w_ta [CS+1];
    logic signed [CW-1:0]    w_rx [CS+1];
    logic signed [CW-1:0]    w_ry [CS+1];
    logic signed [ANG_W-1:0] w_ra [CS+1];

    assign w_tx[0] = r_tx0;
    assign w_ty[0] = r_ty0;
    assign w_ta[0] = '0;
    assign w_rx[0] = r_rx0;
    assign w_ry[0] = r_ry0;
    assign w_ra[0] = r_ra0;

    for (genvar k = 0; k < CS; k++) begin : g_cord
        atpr_cordic_cell #(.CW(CW), .STAGE(k)) u_tilt (
            .i_clk (i_clk),
            .i_en  (w_adv[ST_CORD0+k]),
            .i_x   (w_tx[k]),
            .i_y   (w_ty[k]),
            .i_acc (w_ta[k]),
            .o_x   (w_tx[k+1]),
            .o_y   (w_ty[k+1]),
            .o_acc (w_ta[k+1])
        );
        atpr_cordic_cell #(.CW(CW), .STAGE(k)) u_roll (
            .i_clk (i_clk),
            .i_en  (w_adv[ST_CORD0+k]),
            .i_x   (w_rx[k]),
            .i_y   (w_ry[k]),
            .i_acc (w_ra[k]),
            .o_x   (w_rx[k+1]),
            .o_y   (w_ry[k+1]),
            .o_acc (w_ra[k+1])
        );
    end

    // load flags and magnitude, carry them alongside the CORDIC cells
    always_ff @(posedge i_clk) begin
        if (w_adv[ST_INIT]) begin
            r_tail[0] <= '{tz: w_s.tz, sel: w_s.sel, mag: w_mag};
        end
        for (int k = 0; k < CS; k++) begin
            if (w_adv[ST_CORD0+k]) r_tail[k+1] <= r_tail[k];
        end
    end

    // ---------------------------------------------------------------- rounding
    logic signed [ANG_W-1:0] w_tsum;
    logic signed [ANG_W-1:0] w_rsum;
    logic signed [RND_W-1:0] r_trnd;
    logic signed [RND_W-1:0] r_rrnd;
    t_tail                   r_ftail;

    // round to nearest 0.01 degree, halves away from zero
    assign w_tsum = w_ta[CS] + (w_ta[CS][ANG_W-1] ? RND_NEG : RND_POS);
    assign w_rsum = w_ra[CS] + (w_ra[CS][ANG_W-1] ? RND_NEG : RND_POS);

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_RND]) begin
            r_trnd  <= w_tsum[ANG_W-1:ANG_FRAC];
            r_rrnd  <= w_rsum[ANG_W-1:ANG_FRAC];
            r_ftail <= r_tail[CS];
        end
    end

    // ---------------------------------------------------------------- output word
    logic signed [RND_W-1:0]  w_tclamp;
    logic signed [RND_W-1:0]  w_rclamp;
    logic signed [TILT_W-1:0] w_tilt;
    logic signed [RND_W-1:0]  w_roll;
    logic signed [TILT_W-1:0] r_tilt;
    logic signed [ROLL_W-1:0] r_roll;
    logic [MAG_W-1:0]         r_mag;

    assign w_tclamp = clamp_ang(r_trnd, TILT_LIM);
    assign w_rclamp = clamp_ang(r_rrnd, ROLL_LIM);
    assign w_tilt   = r_ftail.tz ? '0 : w_tclamp[TILT_W-1:0];

    // select the negated roll
    always_comb begin
        case (r_ftail.sel)
            ROLL_VEC:   w_roll = -w_rclamp;
            ROLL_ZERO:  w_roll = '0;
            ROLL_FLIP:  w_roll = -ROLL_LIM;
            ROLL_POS90: w_roll = -RIGHT_DEG;
            ROLL_NEG90: w_roll = RIGHT_DEG;
            default:    w_roll = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_OUT]) begin
            r_tilt <= w_tilt;
            r_roll <= ROLL_W'(w_roll);
            r_mag  <= r_ftail.mag;
        end
    end

    assign o_res.tilt_x_angle   = r_tilt;
    assign o_res.neg_roll_angle = r_roll;
    assign o_res.magnitude      = r_mag;

    // ---------------------------------------------------------------- checks
    // square-root remainder never exceeds twice the root
    a_root_rem : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_INIT-1] |->
            ({1'b0, w_tt_num[SB]} <= {w_tt_res[SB], 1'b0}) &&
            ({1'b0, w_yz_num[SB]} <= {w_yz_res[SB], 1'b0}))
        else $error("square root remainder out of range");

    // CORDIC vectors stay in the right half plane with no overflow
    a_cord_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_RND-1] |->
            !w_tx[CS][CW-1] && !w_rx[CS][CW-1] &&
            (w_ty[CS] <= w_tx[CS]) && (-w_ty[CS] <= w_tx[CS]) &&
            (w_ry[CS] <= w_rx[CS]) && (-w_ry[CS] <= w_rx[CS]))
        else $error("CORDIC vector left its range");

    // input is refused only while every stage is full
    a_full_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_smp.ready |-> (&r_vld) && !o_res.ready)
        else $error("input stalled with an empty stage");
endmodule

// ===== sv/atpr_sqrt_cell.sv =====
// One step of the bitwise integer square root: decides one root bit.
// Stand-alone; chained by the top level.
module atpr_sqrt_cell #(
    parameter int W    = 16,
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [2*W-1:0] i_num,
    input  logic [2*W-1:0] i_res,
    output logic [2*W-1:0] o_num,
    output logic [2*W-1:0] o_res
);
    localparam int NW = 2 * W;
    localparam logic [NW-1:0] BIT = NW'(1) << (2 * (W - 1 - STEP));

    logic [NW-1:0] w_try;
    logic [NW-1:0] n_num;
    logic [NW-1:0] n_res;
    logic [NW-1:0] r_num;
    logic [NW-1:0] r_res;

    // trial subtract of the candidate bit
    always_comb begin
        w_try = i_res + BIT;
        if (i_num >= w_try) begin
            n_num = i_num - w_try;
            n_res = (i_res >> 1) + BIT;
        end else begin
            n_num = i_num;
            n_res = i_res >> 1;
        end
    end

    // hold the partial root and remainder
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= n_num;
            r_res <= n_res;
        end
    end

    assign o_num = r_num;
    assign o_res = r_res;
endmodule

// ===== sv/atpr_cordic_cell.sv =====
// One CORDIC vectoring micro-rotation with its angle update.
// Depends on atpr_pkg for the arctangent table and angle width.
module atpr_cordic_cell #(
    parameter int CW    = 34,
    parameter int STAGE = 0
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [CW-1:0]              i_x,
    input  logic signed [CW-1:0]              i_y,
    input  logic signed [atpr_pkg::ANG_W-1:0] i_acc,
    output logic signed [CW-1:0]              o_x,
    output logic signed [CW-1:0]              o_y,
    output logic signed [atpr_pkg::ANG_W-1:0] o_acc
);
    import atpr_pkg::*;

    localparam logic signed [ANG_W-1:0] ATAN = ATAN_Q12[STAGE];

    logic signed [CW-1:0]    w_dx;
    logic signed [CW-1:0]    w_dy;
    logic signed [CW-1:0]    n_x;
    logic signed [CW-1:0]    n_y;
    logic signed [ANG_W-1:0] n_acc;
    logic signed [CW-1:0]    r_x;
    logic signed [CW-1:0]    r_y;
    logic signed [ANG_W-1:0] r_acc;

    // rotate toward the x axis, steered by the sign of y
    always_comb begin
        w_dx = i_y >>> STAGE;
        w_dy = i_x >>> STAGE;
        if (!i_y[CW-1]) begin
            n_x   = i_x + w_dx;
            n_y   = i_y - w_dy;
            n_acc = i_acc + ATAN;
        end else begin
            n_x   = i_x - w_dx;
            n_y   = i_y + w_dy;
            n_acc = i_acc - ATAN;
        end
    end

    // hand the vector to the next cell
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_acc <= n_acc;
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_acc = r_acc;
endmodule
